### design/lcen_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lcen_pkg;

  // array geometry and fixed-point format
  localparam int NUM_SENSORS   = 8;
  localparam int FRACTION_BITS = 8;
  localparam int READING_W     = 8;
  localparam int POS_W         = 11;

  // derived widths
  localparam int IDX_W   = $clog2(NUM_SENSORS);
  localparam int TOTAL_W = READING_W + $clog2(NUM_SENSORS);
  localparam int WPROD_W = READING_W + IDX_W;
  localparam int WSUM_W  = READING_W + $clog2(NUM_SENSORS * (NUM_SENSORS - 1) / 2 + 1);
  localparam int DVD_W   = WSUM_W + FRACTION_BITS;
  // W <= (N-1)*T, so the quotient never exceeds (N-1) << FRACTION_BITS
  localparam int QUOT_W  = $clog2(((NUM_SENSORS - 1) << FRACTION_BITS) + 1);
  localparam int CNT_W   = $clog2(QUOT_W);
  localparam int HI_W    = DVD_W - QUOT_W;

  // array center in output units
  localparam int CENTRE = (NUM_SENSORS - 1) << (FRACTION_BITS - 1);

  localparam logic signed [POS_W-1:0] POS_MAX = POS_W'(CENTRE);
  localparam logic signed [POS_W-1:0] POS_MIN = -POS_MAX;

  typedef logic [READING_W-1:0] reading_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [WPROD_W-1:0]   wprod_t;
  typedef logic [TOTAL_W-1:0]   total_t;
  typedef logic [WSUM_W-1:0]    wsum_t;
  typedef logic [DVD_W-1:0]     dvd_t;
  typedef logic [QUOT_W-1:0]    quot_t;
  typedef logic signed [POS_W-1:0] pos_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_CHK,
    ST_DIV,
    ST_RES
  } lcen_state_e;

endpackage

`default_nettype wire

### design/lcen_lane.sv
`timescale 1ns / 1ps
`default_nettype none

// One sensor lane: captures its reading and forms the index-weighted value.
module lcen_lane (
  input  wire                 clk_i,
  input  wire                 load_i,
  input  lcen_pkg::reading_t  reading_i,
  input  lcen_pkg::idx_t      idx_i,
  output lcen_pkg::reading_t  reading_o,
  output lcen_pkg::wprod_t    weighted_o
);
  import lcen_pkg::*;

  reading_t reading_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      reading_q <= reading_i;
    end
  end

  assign reading_o  = reading_q;
  assign weighted_o = WPROD_W'(reading_q) * WPROD_W'(idx_i);

endmodule

`default_nettype wire

### design/lcen_merge.sv
`timescale 1ns / 1ps
`default_nettype none

// Merge stage: adds the lane outputs into total and weighted total.
module lcen_merge (
  input  wire                                       clk_i,
  input  wire                                       en_i,
  input  lcen_pkg::reading_t [lcen_pkg::NUM_SENSORS-1:0] reading_i,
  input  lcen_pkg::wprod_t   [lcen_pkg::NUM_SENSORS-1:0] weighted_i,
  output lcen_pkg::total_t                          total_o,
  output lcen_pkg::wsum_t                           wsum_o
);
  import lcen_pkg::*;

  total_t total_d, total_q;
  wsum_t  wsum_d, wsum_q;

  always_comb begin
    total_d = '0;
    wsum_d  = '0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      total_d = total_d + TOTAL_W'(reading_i[i]);
      wsum_d  = wsum_d + WSUM_W'(weighted_i[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      total_q <= total_d;
      wsum_q  <= wsum_d;
    end
  end

  assign total_o = total_q;
  assign wsum_o  = wsum_q;

endmodule

`default_nettype wire

### design/lcen_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle. The quotient is known to
// fit in QUOT_W bits, so the upper dividend bits preload the remainder.
module lcen_div (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start_i,
  input  lcen_pkg::dvd_t    dividend_i,
  input  lcen_pkg::total_t  divisor_i,
  output logic              done_o,
  output lcen_pkg::quot_t   quot_o
);
  import lcen_pkg::*;

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  total_t           rem_q, rem_d;
  quot_t            lo_q;
  quot_t            quot_q;
  logic [TOTAL_W:0] trial;
  logic [TOTAL_W:0] diff;
  logic             ge;

  always_comb begin
    trial = {rem_q, lo_q[QUOT_W-1]};
    diff  = trial - {1'b0, divisor_i};
    ge    = trial >= {1'b0, divisor_i};
    rem_d = ge ? diff[TOTAL_W-1:0] : trial[TOTAL_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(QUOT_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= TOTAL_W'(dividend_i[DVD_W-1:QUOT_W]);
      lo_q   <= dividend_i[QUOT_W-1:0];
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      lo_q   <= {lo_q[QUOT_W-2:0], 1'b0};
      quot_q <= {quot_q[QUOT_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

### design/line_position_centroid.sv
// Line position by weighted centroid over eight sensor lanes.
// Path from input accept to output valid: merge, check, divider steps,
//   done handoff, output load; a held word skips the divider.
// The bit-serial divider makes one quotient bit per cycle. A new word is
//   taken only once the last has been loaded into the output register.
// Reset (rst_ni low, async): control idle, output empty, held position 0.
`timescale 1ns / 1ps
`default_nettype none

module line_position_centroid (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  lcen_pkg::reading_t  reading_0_i,
  input  lcen_pkg::reading_t  reading_1_i,
  input  lcen_pkg::reading_t  reading_2_i,
  input  lcen_pkg::reading_t  reading_3_i,
  input  lcen_pkg::reading_t  reading_4_i,
  input  lcen_pkg::reading_t  reading_5_i,
  input  lcen_pkg::reading_t  reading_6_i,
  input  lcen_pkg::reading_t  reading_7_i,
  input  wire                 scan_complete_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output lcen_pkg::pos_t      position_o,
  output logic                held_o
);
  import lcen_pkg::*;

  // sequencer
  lcen_state_e state_q, state_d;

  logic lane_load;
  logic sum_en;
  logic div_start;
  logic out_load;
  logic out_free;
  logic hold_cond;

  // input capture / lanes
  reading_t [NUM_SENSORS-1:0] rd_in;
  reading_t [NUM_SENSORS-1:0] rd_lane;
  wprod_t   [NUM_SENSORS-1:0] wt_lane;
  logic                       cmp_q;

  // merge and divide
  total_t total;
  wsum_t  wsum;
  dvd_t   dividend;
  quot_t  quot;
  logic   div_done;

  // result side
  logic hold_q;
  pos_t last_pos_q;
  pos_t pos_new;
  logic out_valid_q;
  pos_t pos_q;
  logic held_q;

  assign rd_in[0] = reading_0_i;
  assign rd_in[1] = reading_1_i;
  assign rd_in[2] = reading_2_i;
  assign rd_in[3] = reading_3_i;
  assign rd_in[4] = reading_4_i;
  assign rd_in[5] = reading_5_i;
  assign rd_in[6] = reading_6_i;
  assign rd_in[7] = reading_7_i;

  // one lane per sensor element, weight = element index
  for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_lane
    lcen_lane u_lane (
      .clk_i      (clk_i),
      .load_i     (lane_load),
      .reading_i  (rd_in[g]),
      .idx_i      (IDX_W'(g)),
      .reading_o  (rd_lane[g]),
      .weighted_o (wt_lane[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (lane_load) begin
      cmp_q <= scan_complete_i;
    end
  end

  lcen_merge u_merge (
    .clk_i      (clk_i),
    .en_i       (sum_en),
    .reading_i  (rd_lane),
    .weighted_i (wt_lane),
    .total_o    (total),
    .wsum_o     (wsum)
  );

  // Q = (W << FRACTION_BITS) / T
  assign dividend = DVD_W'(wsum) << FRACTION_BITS;

  lcen_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (total),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // incomplete scan or dark array: repeat the last good position
  assign hold_cond = !cmp_q || (total == '0);

  // output register parts the two sides; a new word may be taken while
  // a finished word still waits downstream
  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        state_d = ST_CHK;
      end
      ST_CHK: begin
        state_d = hold_cond ? ST_RES : ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_RES;
        end
      end
      ST_RES: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    sum_en     = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_SUM: begin
        sum_en = 1'b1;
      end
      ST_CHK: begin
        div_start = !hold_cond;
      end
      ST_DIV: begin
      end
      ST_RES: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  assign lane_load = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CHK) begin
      hold_q <= hold_cond;
    end
  end

  // re-center: subtract half the array span, wrap to output width
  assign pos_new = hold_q ? last_pos_q : (POS_W'(quot) - POS_W'(CENTRE));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      last_pos_q  <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        if (!hold_q) begin
          last_pos_q <= pos_new;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pos_q  <= pos_new;
      held_q <= hold_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign position_o  = pos_q;
  assign held_o      = held_q;

endmodule

`default_nettype wire

### design/lcen_chk.sv
`timescale 1ns / 1ps
`default_nettype none

// Port-level checks for line_position_centroid.
module lcen_chk (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 in_valid_i,
  input wire                 in_ready_o,
  input wire                 out_valid_o,
  input wire                 out_ready_i,
  input lcen_pkg::pos_t      position_o,
  input wire                 held_o
);
  import lcen_pkg::*;

  pos_t last_q;

  // last delivered position, as seen downstream
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      last_q <= position_o;
    end
  end

  // an output word is not dropped while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped under stall");

  // one word at a time: input closes right after an accept
  a_in_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input reopened right after accept");

  // a held word repeats the previous position
  a_held_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && held_o |-> position_o == last_q)
    else $error("held position differs from last delivered position");

  // centroid stays within the array span
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(position_o) <= POS_MAX) && ($signed(position_o) >= POS_MIN))
    else $error("position out of range");

endmodule

bind line_position_centroid lcen_chk u_lcen_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .position_o  (position_o),
  .held_o      (held_o)
);

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import lcen_pkg::*;

  // A scan packed as one vector: element i is the reading of sensor i.
  typedef logic [NUM_SENSORS-1:0][READING_W-1:0] scan_t;

  // One output word as the block should deliver it.
  typedef struct packed {
    pos_t position;
    logic held;
  } pos_word_t;

  localparam int RANDOM_SCANS = 1300;
  localparam int QUIET_TAIL   = 150;   // last scans run with no idling at all
  localparam int DRAIN_AT     = 600;   // sender pauses here until all words are back
  localparam int LONG_HOLD    = 250;   // receiver hold-off, in cycles
  localparam int HOLD_AFTER   = 400;   // words checked before the hold-off starts
  localparam int SETTLE       = 40;    // cycles after the last word
  localparam int MAX_REPORTS  = 10;

  // Tracks the remembered position and the words still owed by the block.
  class position_scoreboard;
    pos_t      remembered;
    pos_word_t owed_q[$];
    int        failures;
    int        checked;
    int        scans;
    int        complete_scans;
    int        held_words;
    pos_t      lo_seen;
    pos_t      hi_seen;

    function new();
      remembered     = '0;
      failures       = 0;
      checked        = 0;
      scans          = 0;
      complete_scans = 0;
      held_words     = 0;
      lo_seen        = POS_MAX;
      hi_seen        = POS_MIN;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Centroid of an accepted scan, re-centered; incomplete or empty scans
    // repeat the remembered position.
    function void note_scan(scan_t s, logic complete);
      int unsigned total;
      int unsigned weighted;
      int unsigned quot;
      pos_word_t   w;
      total    = 0;
      weighted = 0;
      scans++;
      if (complete) begin
        complete_scans++;
        for (int i = 0; i < NUM_SENSORS; i++) begin
          total    += s[i];
          weighted += i * s[i];
        end
      end
      if (!complete || total == 0) begin
        w.position = remembered;
        w.held     = 1'b1;
        held_words++;
      end else begin
        quot       = (weighted << FRACTION_BITS) / total;
        w.position = pos_t'(quot - CENTRE);
        w.held     = 1'b0;
        remembered = w.position;
        if (w.position < lo_seen) lo_seen = w.position;
        if (w.position > hi_seen) hi_seen = w.position;
      end
      owed_q.push_back(w);
    endfunction

    function void flag(string what, int exp_v, int got_v);
      failures++;
      if (failures <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, exp_v, got_v);
    endfunction

    function void check_result(pos_t position, logic held);
      pos_word_t exp_w;
      checked++;
      if (owed_q.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%0t: unexpected word: position %0d held %b", $time,
                   int'(position), held);
        return;
      end
      exp_w = owed_q.pop_front();
      if (position !== exp_w.position) flag("position", int'(exp_w.position), int'(position));
      if (held !== exp_w.held) flag("held", int'(exp_w.held), int'(held));
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  reading_t reading_0_i, reading_1_i, reading_2_i, reading_3_i;
  reading_t reading_4_i, reading_5_i, reading_6_i, reading_7_i;
  logic     scan_complete_i;
  logic     out_valid_o;
  logic     out_ready_i;
  pos_t     position_o;
  logic     held_o;

  position_scoreboard sb;
  int                 idle_pct;     // sender idle odds, changed in phases
  bit                 calm;         // set for the tail of the run: no idling

  line_position_centroid uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .reading_0_i     (reading_0_i),
    .reading_1_i     (reading_1_i),
    .reading_2_i     (reading_2_i),
    .reading_3_i     (reading_3_i),
    .reading_4_i     (reading_4_i),
    .reading_5_i     (reading_5_i),
    .reading_6_i     (reading_6_i),
    .reading_7_i     (reading_7_i),
    .scan_complete_i (scan_complete_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .position_o      (position_o),
    .held_o          (held_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Monitors sample at the edge, before the edge's updates land.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      sb.note_scan({reading_7_i, reading_6_i, reading_5_i, reading_4_i,
                    reading_3_i, reading_2_i, reading_1_i, reading_0_i},
                   scan_complete_i);
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(position_o, held_o);
  end

  // Offer one scan and hold it until the block takes it; valid stays high
  // if the next call follows straight away.
  task automatic offer_scan(scan_t s, logic complete);
    in_valid_i      <= 1'b1;
    reading_0_i     <= s[0];
    reading_1_i     <= s[1];
    reading_2_i     <= s[2];
    reading_3_i     <= s[3];
    reading_4_i     <= s[4];
    reading_5_i     <= s[5];
    reading_6_i     <= s[6];
    reading_7_i     <= s[7];
    scan_complete_i <= complete;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    // random gap after the word, in bursts
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait for every owed word to come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Random scan, weighted toward line-shaped profiles, with some fully random
  // bytes, sparse scans, empty scans and incomplete scans mixed in.
  task automatic make_scan(output scan_t s, output logic complete);
    int kind;
    int c;
    int peak;
    kind     = $urandom_range(0, 99);
    complete = 1'b1;
    s        = '0;
    if (kind < 55) begin
      c    = $urandom_range(0, NUM_SENSORS - 1);
      peak = ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(1, 255);
      for (int i = 0; i < NUM_SENSORS; i++)
        s[i] = ($urandom_range(0, 2) == 0) ? reading_t'($urandom_range(0, 15)) : '0;
      s[c] = reading_t'(peak);
      if (c > 0) s[c-1] = reading_t'($urandom_range(0, peak));
      if (c < NUM_SENSORS - 1) s[c+1] = reading_t'($urandom_range(0, peak));
    end else if (kind < 80) begin
      for (int i = 0; i < NUM_SENSORS; i++) s[i] = reading_t'($urandom());
    end else if (kind < 88) begin
      for (int i = 0; i < NUM_SENSORS; i++)
        if ($urandom_range(0, 3) == 0) s[i] = reading_t'($urandom());
    end else if (kind < 93) begin
      s = '0;
    end else begin
      // incomplete scan: readings are junk and must be ignored
      for (int i = 0; i < NUM_SENSORS; i++) s[i] = reading_t'($urandom());
      complete = 1'b0;
    end
  endtask

  // Receiver: random stall bursts in phases, one long hold-off so the block
  // fills and stalls its input, and no stalls in the quiet tail.
  initial begin : receiver
    bit held_off;
    int stall_pct;
    int cyc;
    held_off  = 0;
    stall_pct = 20;
    cyc       = 0;
    out_ready_i = 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (cyc % 128 == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 20;
          default: stall_pct = 50;
        endcase
      end
      if (!held_off && sb.checked >= HOLD_AFTER) begin
        held_off    = 1;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        cyc += LONG_HOLD;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 11)) begin
          @(posedge clk_i);
          cyc++;
        end
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
        cyc++;
      end
    end
  end

  // Sender: reset, directed scans, then the random run.
  initial begin : sender
    scan_t s;
    logic  complete;
    sb              = new();
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    reading_0_i     = '0;
    reading_1_i     = '0;
    reading_2_i     = '0;
    reading_3_i     = '0;
    reading_4_i     = '0;
    reading_5_i     = '0;
    reading_6_i     = '0;
    reading_7_i     = '0;
    scan_complete_i = 1'b0;
    idle_pct        = 10;
    calm            = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // incomplete scan right after reset repeats the reset position
    offer_scan(64'hA5A5_A5A5_A5A5_A5A5, 1'b0);
    // all-zero scan: nothing to divide by, position held
    offer_scan('0, 1'b1);
    // line under the leftmost sensor: lowest position
    offer_scan(64'h0000_0000_0000_00FF, 1'b1);
    offer_scan('0, 1'b1);
    // line under the rightmost sensor: highest position
    offer_scan(64'hFF00_0000_0000_0000, 1'b1);
    offer_scan(64'h0101_0101_0101_0101, 1'b0);
    // flat full-scale scan sits dead center
    offer_scan('1, 1'b1);
    // smallest nonzero reading on each sensor in turn
    for (int i = 0; i < NUM_SENSORS; i++) begin
      s    = '0;
      s[i] = 8'd1;
      offer_scan(s, 1'b1);
    end
    offer_scan(64'h0055_0055_0055_0055, 1'b1);
    offer_scan(64'hAA00_AA00_AA00_AA00, 1'b1);
    // lopsided extremes: truncated quotient near each end
    offer_scan(64'hFF00_0000_0000_0001, 1'b1);
    offer_scan(64'h0100_0000_0000_00FF, 1'b1);
    offer_scan('0, 1'b0);

    for (int k = 0; k < RANDOM_SCANS; k++) begin
      if (k % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 10;
          default: idle_pct = 40;
        endcase
      end
      if (k == RANDOM_SCANS - QUIET_TAIL) calm = 1;
      if (k == DRAIN_AT) wait_drained();
      make_scan(s, complete);
      offer_scan(s, complete);
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    $display("Ran %0d scans (%0d complete), checked %0d words, %0d held",
             sb.scans, sb.complete_scans, sb.checked, sb.held_words);
    $display("Fresh positions spanned %0d to %0d; %0d failures",
             int'(sb.lo_seen), int'(sb.hi_seen), sb.failures);
    if (sb.failures == 0 && sb.pending() == 0)
      $display("[line_position_centroid] OK");
    else
      $display("[line_position_centroid] ERROR");
    $finish;
  end

  // Watchdog: well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Timeout with %0d words still owed", sb.pending());
    $display("[line_position_centroid] ERROR");
    $finish;
  end

endmodule
